>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker mt64_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hw/rtl/mt64_pkg.sv
`default_nettype none

package mt64_pkg;

  localparam int STATE_WORDS   = 312;
  localparam int MIDDLE_OFFSET = 156;

  localparam logic [63:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] SEED_MULT    = 64'd6364136223846793005;
  localparam logic [63:0] DEFAULT_SEED = 64'd5489;

  localparam logic [63:0] TEMPER_MASK_B = 64'h5555_5555_5555_5555;
  localparam logic [63:0] TEMPER_MASK_C = 64'h71D6_7FFF_EDA6_0000;
  localparam logic [63:0] TEMPER_MASK_D = 64'hFFF7_EEE0_0000_0000;

  // Status of the seeding unit toward the controller.
  typedef struct packed {
    logic wr_en;
    logic done;
  } mt64_seed_stat_t;

  function automatic logic [63:0] temper(input logic [63:0] v);
    logic [63:0] t;
    t = v;
    t = t ^ ((t >> 29) & TEMPER_MASK_B);
    t = t ^ ((t << 17) & TEMPER_MASK_C);
    t = t ^ ((t << 37) & TEMPER_MASK_D);
    t = t ^ (t >> 43);
    return t;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mt64_mem.sv
`default_nettype none

// Word pool: one write port, two registered read ports.
module mt64_mem #(
  parameter int DEPTH = mt64_pkg::STATE_WORDS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [63:0]   wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic [63:0]        rdata_a,
  output logic [63:0]        rdata_b
);

  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

>>> hw/rtl/mt64_seed.sv
`default_nettype none

// Seeding unit. Word k is 6364136223846793005 * (w ^ (w >> 62)) + k,
// formed with one shared 32x32 multiplier over three partial products.
module mt64_seed #(
  parameter int DEPTH = mt64_pkg::STATE_WORDS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     go,
  input  wire logic [63:0]              seed,
  output mt64_pkg::mt64_seed_stat_t     stat,
  output logic [AW-1:0]                 wr_addr,
  output logic [63:0]                   wr_data
);

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_MLL   = 5'b00010,
    PH_MLH   = 5'b00100,
    PH_MHL   = 5'b01000,
    PH_WRITE = 5'b10000
  } mt64_phase_t;

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [31:0]   MULT_LO  = mt64_pkg::SEED_MULT[31:0];
  localparam logic [31:0]   MULT_HI  = mt64_pkg::SEED_MULT[63:32];

  mt64_phase_t   phase_r, phase_nxt;
  logic [AW-1:0] idx_r;
  logic [63:0]   prev_r;
  logic [63:0]   acc_r;
  logic [63:0]   mul_r;
  logic [63:0]   mixed;
  logic [31:0]   op_a;
  logic [31:0]   op_b;
  logic [63:0]   word;

  assign mixed   = prev_r ^ (prev_r >> 62);
  assign op_a    = (phase_r == PH_MHL) ? mixed[63:32] : mixed[31:0];
  assign op_b    = (phase_r == PH_MLH) ? MULT_HI : MULT_LO;
  assign word    = acc_r + {mul_r[31:0], 32'd0};
  assign wr_addr = idx_r;
  assign wr_data = word;

  assign stat.wr_en = (phase_r == PH_WRITE);
  assign stat.done  = (phase_r == PH_WRITE) && (idx_r == LAST_IDX);

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE:  phase_nxt = go ? PH_WRITE : PH_IDLE;
      PH_MLL:   phase_nxt = PH_MLH;
      PH_MLH:   phase_nxt = PH_MHL;
      PH_MHL:   phase_nxt = PH_WRITE;
      PH_WRITE: phase_nxt = (idx_r == LAST_IDX) ? PH_IDLE : PH_MLL;
      default:  phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((phase_r == PH_IDLE) && go) begin
      acc_r <= seed;
      mul_r <= '0;
      idx_r <= '0;
    end else begin
      if ((phase_r == PH_MLL) || (phase_r == PH_MLH) || (phase_r == PH_MHL)) begin
        mul_r <= 64'(op_a) * 64'(op_b);
      end
      if (phase_r == PH_MLH) begin
        acc_r <= mul_r + {{(64 - AW){1'b0}}, idx_r};
      end
      if (phase_r == PH_MHL) begin
        acc_r <= word;
      end
      if (phase_r == PH_WRITE) begin
        prev_r <= word;
        idx_r  <= idx_r + AW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mersenne_twister_64_generator.sv
// A generate transaction from a pool with words left goes IDLE -> GEN; its tempered word is registered in GEN.
// A new transaction is taken only back in IDLE; every 312th word first twists the pool.
// A reseed transaction writes the pool word by word, each word formed in turn by the shared multiplier.
// Reset is synchronous, active low; the block then reads as never seeded.
// The first generate transaction without a seed seeds with 5489, then twists.
`default_nettype none

module mersenne_twister_64_generator #(
  parameter int STATE_WORDS = mt64_pkg::STATE_WORDS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_func,
  input  wire logic [63:0] in_seed_value,
  output logic             out_valid,
  output logic [63:0]      out_random_word
);

  // Address width of the pool and width of the read position, which also has to
  // hold "pool used up" (STATE_WORDS) and "never seeded" (STATE_WORDS + 1).
  localparam int AW = $clog2(STATE_WORDS);
  localparam int PW = $clog2(STATE_WORDS + 2);

  localparam logic [PW-1:0] POS_FULL     = PW'(STATE_WORDS);
  localparam logic [PW-1:0] POS_UNSEEDED = PW'(STATE_WORDS + 1);
  localparam logic [AW:0]   DEPTH_X      = (AW + 1)'(STATE_WORDS);
  localparam logic [AW:0]   MID_X        = (AW + 1)'(mt64_pkg::MIDDLE_OFFSET);
  localparam logic [AW-1:0] LAST_IDX     = AW'(STATE_WORDS - 1);

  // Controller states. A generate transaction from a fresh pool goes
  // IDLE -> GEN. One that needs a twist goes IDLE -> TW_PRIME -> TW_LOAD ->
  // TW_RUN (one word per cycle) -> GEN. A reseed, or a generate on a block never
  // seeded, sits in SEED while the seeding unit fills the pool; the generate then twists.
  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SEED     = 6'b000010,
    ST_TW_PRIME = 6'b000100,
    ST_TW_LOAD  = 6'b001000,
    ST_TW_RUN   = 6'b010000,
    ST_GEN      = 6'b100000
  } mt64_state_t;

  mt64_state_t state_r, state_nxt;
  logic [PW-1:0] pos_r;
  logic [AW-1:0] k_r;
  logic [63:0]   cur_r;
  logic          gen_pend_r;
  logic          out_valid_r;
  logic [63:0]   out_word_r;

  logic          accept;
  logic          seed_go;
  logic [63:0]   seed_word;
  logic [AW:0]   step_x;
  logic [AW-1:0] next_idx;
  logic [AW-1:0] far_idx;
  logic [AW-1:0] raddr_a;
  logic [63:0]   rdata_a;
  logic [63:0]   rdata_b;
  logic [63:0]   joined;
  logic [63:0]   twisted;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;

  mt64_pkg::mt64_seed_stat_t seed_stat;
  logic [AW-1:0]             seed_waddr;
  logic [63:0]               seed_wdata;

  // Index sum known to stay below twice the depth: one compare and subtract.
  function automatic logic [AW-1:0] wrap_idx(input logic [AW:0] s);
    logic [AW:0] d;
    d = s - DEPTH_X;
    return (s >= DEPTH_X) ? d[AW-1:0] : s[AW-1:0];
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // A reseed transaction, or a generate transaction on a block never seeded,
  // starts the seeding unit in the cycle of acceptance.
  assign seed_go   = accept && (in_func || (pos_r == POS_UNSEEDED));
  assign seed_word = in_func ? in_seed_value : mt64_pkg::DEFAULT_SEED;

  mt64_seed #(
    .DEPTH (STATE_WORDS)
  ) u_seed (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (seed_go),
    .seed    (seed_word),
    .stat    (seed_stat),
    .wr_addr (seed_waddr),
    .wr_data (seed_wdata)
  );

  // Twist pipeline. The reads for step j (words j+1 and j+156, modulo the
  // depth) are issued in the cycle before; word j itself is the word read as
  // "next" by the step before, held in cur_r. Step j writes word j in the
  // same cycle as the reads of step j+1 are issued, and those never address
  // word j, so no forwarding is needed. Wrapped reads of words already
  // rewritten see the new values, as the in-place recurrence requires.
  assign step_x   = (state_r == ST_TW_LOAD) ? '0 : ({1'b0, k_r} + (AW + 1)'(1));
  assign next_idx = wrap_idx(step_x + (AW + 1)'(1));
  assign far_idx  = wrap_idx(step_x + MID_X);

  assign joined  = {cur_r[63:31], rdata_a[30:0]};
  assign twisted = rdata_b ^ (joined >> 1) ^ (joined[0] ? mt64_pkg::TWIST_MATRIX : 64'd0);

  // Port A serves the twist "next" reads and the generate read. In IDLE it
  // reads at the read position so the word is ready when a generate
  // transaction is accepted; in the last twist cycle it fetches word 0.
  always_comb begin
    raddr_a = '0;
    unique case (state_r)
      ST_IDLE:     raddr_a = (pos_r < POS_FULL) ? pos_r[AW-1:0] : '0;
      ST_TW_LOAD:  raddr_a = next_idx;
      ST_TW_RUN:   raddr_a = (k_r == LAST_IDX) ? '0 : next_idx;
      ST_SEED, ST_TW_PRIME, ST_GEN: raddr_a = '0;
      default:     raddr_a = '0;
    endcase
  end

  always_comb begin
    if (state_r == ST_TW_RUN) begin
      mem_we    = 1'b1;
      mem_waddr = k_r;
      mem_wdata = twisted;
    end else begin
      mem_we    = seed_stat.wr_en;
      mem_waddr = seed_waddr;
      mem_wdata = seed_wdata;
    end
  end

  mt64_mem #(
    .DEPTH (STATE_WORDS)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (raddr_a),
    .raddr_b (far_idx),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (seed_go) begin
            state_nxt = ST_SEED;
          end else if (pos_r == POS_FULL) begin
            state_nxt = ST_TW_PRIME;
          end else begin
            state_nxt = ST_GEN;
          end
        end
      end
      ST_SEED: begin
        if (seed_stat.done) begin
          state_nxt = gen_pend_r ? ST_TW_PRIME : ST_IDLE;
        end
      end
      ST_TW_PRIME: state_nxt = ST_TW_LOAD;
      ST_TW_LOAD:  state_nxt = ST_TW_RUN;
      ST_TW_RUN:   state_nxt = (k_r == LAST_IDX) ? ST_GEN : ST_TW_RUN;
      ST_GEN:      state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= POS_UNSEEDED;
      gen_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_GEN);
      if (seed_go) begin
        gen_pend_r <= !in_func;
      end
      if ((state_r == ST_SEED) && seed_stat.done) begin
        pos_r <= POS_FULL;
      end
      if (state_r == ST_TW_LOAD) begin
        k_r <= '0;
      end
      if (state_r == ST_TW_RUN) begin
        if (k_r == LAST_IDX) begin
          pos_r <= '0;
        end else begin
          k_r <= k_r + AW'(1);
        end
      end
      if (state_r == ST_GEN) begin
        pos_r <= pos_r + PW'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if ((state_r == ST_TW_LOAD) || (state_r == ST_TW_RUN)) begin
      cur_r <= rdata_a;
    end
    if (state_r == ST_GEN) begin
      out_word_r <= mt64_pkg::temper(rdata_a);
    end
  end

  // Each result transaction shows for exactly one cycle.
  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

endmodule

`default_nettype wire

>>> hw/rtl/mt64_chk.sv
`default_nettype none

`include "assert_macros.svh"

module mt64_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        in_func,
  input wire logic        out_valid
);

  logic accept;
  assign accept = start && !busy;

  // The controller passes IDLE again between two words, so results never come back to back.
  `ASSERT_NEXT(a_no_back_to_back, out_valid, !out_valid)
  // A result always closes a stretch of work.
  `ASSERT_SAME(a_result_after_busy, out_valid, $past(busy))
  // A reseed transaction keeps the block busy while the pool is filled.
  `ASSERT_NEXT(a_reseed_busy, accept && in_func, busy && !out_valid)
  // No result appears in the cycle right after any accepted transaction.
  `ASSERT_NEXT(a_no_early_result, accept, !out_valid)

endmodule

bind mersenne_twister_64_generator mt64_chk u_chk (.*);

`default_nettype wire

>>> test/mersenne_twister_64_generator_tb.sv
`default_nettype none

module mersenne_twister_64_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Sizes and constants of the 64-bit Mersenne Twister, kept apart from the package
  // so that the predictor does not inherit a wrong constant from the design.
  localparam int POOL_SIZE = 312;
  localparam int POOL_MIDDLE = 156;
  localparam int NEVER_SEEDED = POOL_SIZE + 1;
  localparam logic [63:0] TWIST_POLY = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] UPPER_BITS = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] LOWER_BITS = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] INIT_MULT = 64'd6364136223846793005;
  localparam logic [63:0] BOOT_SEED = 64'd5489;
  localparam logic [63:0] SHIFT_MASK_U = 64'h5555_5555_5555_5555;
  localparam logic [63:0] SHIFT_MASK_S = 64'h71D6_7FFF_EDA6_0000;
  localparam logic [63:0] SHIFT_MASK_T = 64'hFFF7_EEE0_0000_0000;

  // Stimulus size and the watchdog limit. The slowest stretch without any transaction
  // is a generate on a block never seeded: the seeding and a twist of the pool come
  // before its word, so the limit leaves a wide margin.
  localparam int ITEM_TARGET = 1400;
  localparam int IDLE_LIMIT = 20000;
  localparam int MAX_REPORTS = 10;

  typedef enum logic {
    REQ_GENERATE = 1'b0,
    REQ_RESEED   = 1'b1
  } request_kind_t;

  typedef struct {
    request_kind_t kind;
    logic [63:0]   seed;
  } request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        in_func = 1'b0;
  logic [63:0] in_seed_value = 64'd0;
  logic        busy;
  logic        out_valid;
  logic [63:0] out_random_word;

  mersenne_twister_64_generator u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_seed_value  (in_seed_value),
    .out_valid      (out_valid),
    .out_random_word(out_random_word)
  );

  always #5 clk = ~clk;

  // Predictor state: a private copy of the word pool and the read pointer.
  logic [63:0] pool_words [POOL_SIZE];
  int          pool_index = NEVER_SEEDED;

  request_t    pending_requests [$];
  logic [63:0] expected_words [$];
  int          total_requests = 0;
  int          accepted_count = 0;
  int          failure_count = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Seeds lean toward the corner values now and then: zero, all ones and single bits.
  function automatic logic [63:0] rand_seed();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 64'd0;
    if (pick < 15) return '1;
    if (pick < 22) return 64'd1 << $urandom_range(63);
    return rand64();
  endfunction

  function automatic void add_request(request_kind_t kind, logic [63:0] seed);
    request_t r;
    r.kind = kind;
    r.seed = seed;
    pending_requests.push_back(r);
  endfunction

  // Fill the pool by the multiplicative recurrence; the next generate twists first.
  function automatic void seed_pool(logic [63:0] seed);
    logic [63:0] prev;
    pool_words[0] = seed;
    for (int k = 1; k < POOL_SIZE; k++) begin
      prev = pool_words[k-1];
      pool_words[k] = INIT_MULT * (prev ^ (prev >> 62)) + 64'(k);
    end
    pool_index = POOL_SIZE;
  endfunction

  // Regenerate the pool in place. Later words see the already updated early words
  // through the wrap of the far index, exactly as the sequential algorithm does.
  function automatic void twist_pool();
    logic [63:0] joined;
    logic [63:0] mixed;
    for (int k = 0; k < POOL_SIZE; k++) begin
      joined = (pool_words[k] & UPPER_BITS) | (pool_words[(k + 1) % POOL_SIZE] & LOWER_BITS);
      mixed = joined >> 1;
      if (joined[0]) mixed = mixed ^ TWIST_POLY;
      pool_words[k] = pool_words[(k + POOL_MIDDLE) % POOL_SIZE] ^ mixed;
    end
    pool_index = 0;
  endfunction

  function automatic logic [63:0] temper_word(logic [63:0] raw);
    logic [63:0] v;
    v = raw;
    v = v ^ ((v >> 29) & SHIFT_MASK_U);
    v = v ^ ((v << 17) & SHIFT_MASK_S);
    v = v ^ ((v << 37) & SHIFT_MASK_T);
    v = v ^ (v >> 43);
    return v;
  endfunction

  // Advance the predictor by one accepted transaction. A reseed leaves nothing to
  // check; a generate queues the tempered word it must produce.
  function automatic void predict_request(request_kind_t kind, logic [63:0] seed);
    if (kind == REQ_RESEED) begin
      seed_pool(seed);
    end else begin
      if (pool_index >= POOL_SIZE) begin
        if (pool_index == NEVER_SEEDED) seed_pool(BOOT_SEED);
        twist_pool();
      end
      expected_words.push_back(temper_word(pool_words[pool_index]));
      pool_index = pool_index + 1;
    end
  endfunction

  // Sender gaps: mostly back to back or short, a few long, with occasional bursts
  // that run many transactions without any gap at all.
  function automatic int pick_gap();
    int pick;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(99);
    if (pick < 2) begin
      burst_left = $urandom_range(120, 30);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(3, 1);
    if (pick < 97) return $urandom_range(12, 4);
    return $urandom_range(90, 30);
  endfunction

  task automatic record_failure(string what, logic [63:0] want, logic [63:0] got);
    failure_count++;
    if (failure_count <= MAX_REPORTS)
      $display("mismatch: %s, expected %h, got %h", what, want, got);
  endtask

  task automatic load_next();
    request_t r;
    r = pending_requests.pop_front();
    start <= 1'b1;
    in_func <= r.kind;
    in_seed_value <= r.seed;
  endtask

  // Driver. All decisions use the values from before the edge, so a transaction is
  // taken exactly when the design sees start high and busy low. Start is assigned at
  // most once per edge: when a transaction completes and another follows without a
  // gap, start simply stays high while the payload changes.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      predict_request(request_kind_t'(in_func), in_seed_value);
      accepted_count++;
      gap_left = pick_gap();
      if (gap_left == 0 && pending_requests.size() != 0) begin
        load_next();
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_requests.size() != 0) begin
        load_next();
      end
    end
  end

  // Monitor. The receiver can never hold results off, so every strobe is a result
  // transaction and is checked against the oldest predicted word.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        record_failure("result with no request waiting", 64'd0, out_random_word);
      end else begin
        logic [63:0] want;
        want = expected_words.pop_front();
        if (out_random_word !== want) record_failure("random_word", want, out_random_word);
      end
    end
  end

  // Watchdog: counts cycles in which no transaction of either kind takes place.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
          $display("FAIL mersenne_twister_64_generator");
          $finish;
        end
      end
    end
  end

  initial begin
    int pick;
    int run_len;

    // Directed part. The very first request is a generate, so the block must seed
    // itself with the default seed and twist before its first word. The ignored seed
    // field carries noise on generates. Then zero and all-ones seeds, an explicit
    // default seed, two reseeds back to back, and a seed with only the top bit set.
    add_request(REQ_GENERATE, '1);
    add_request(REQ_GENERATE, 64'd0);
    add_request(REQ_GENERATE, rand64());
    add_request(REQ_RESEED, 64'd0);
    add_request(REQ_GENERATE, '1);
    add_request(REQ_GENERATE, rand64());
    add_request(REQ_RESEED, '1);
    add_request(REQ_GENERATE, 64'd0);
    add_request(REQ_RESEED, BOOT_SEED);
    add_request(REQ_RESEED, 64'd1);
    add_request(REQ_GENERATE, rand64());
    add_request(REQ_RESEED, 64'h8000_0000_0000_0000);
    add_request(REQ_GENERATE, rand64());
    add_request(REQ_GENERATE, rand64());
    add_request(REQ_RESEED, 64'hFFFF_FFFF_0000_0000);
    add_request(REQ_GENERATE, rand64());
    add_request(REQ_GENERATE, rand64());

    // Random part. It opens with one full pass over the pool plus one word, so the
    // twist after a used-up pool is surely reached. After that come segments of
    // generate runs of mixed length, most of them behind a fresh seed. Short runs
    // put reseeds close together; long runs cross the pool boundary again. The last
    // run is cut so that the total stays at the target.
    add_request(REQ_RESEED, rand_seed());
    repeat (POOL_SIZE + 1) add_request(REQ_GENERATE, rand64());
    while (pending_requests.size() < ITEM_TARGET) begin
      if ($urandom_range(99) < 75) add_request(REQ_RESEED, rand_seed());
      pick = $urandom_range(99);
      if (pick < 30) run_len = $urandom_range(5);
      else if (pick < 70) run_len = $urandom_range(350, 20);
      else run_len = $urandom_range(700, 300);
      if (run_len > ITEM_TARGET - pending_requests.size())
        run_len = ITEM_TARGET - pending_requests.size();
      repeat (run_len) add_request(REQ_GENERATE, rand64());
    end
    total_requests = pending_requests.size();

    // Reset is asserted once, at the start, and never again.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to be taken and every predicted word to come back.
    // A trailing reseed gives no result, so busy must also fall before the tail.
    while (accepted_count < total_requests) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (8) @(posedge clk);

    if (expected_words.size() != 0)
      record_failure("words still expected at the end", expected_words[0], 64'd0);

    if (failure_count == 0) begin
      $display("PASS mersenne_twister_64_generator");
    end else begin
      $display("FAIL mersenne_twister_64_generator");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> mersenne_twister_64_generator.f
+incdir+hw/rtl
hw/rtl/mt64_pkg.sv
hw/rtl/mt64_mem.sv
hw/rtl/mt64_seed.sv
hw/rtl/mersenne_twister_64_generator.sv
hw/rtl/mt64_chk.sv
test/mersenne_twister_64_generator_tb.sv
